// ===== sv/obs_pkg.sv =====
// obs_pkg: beat types, command and status structs and constants for owner_bucket_scatter
// no dependencies; used by obs_ctrl, obs_datapath and owner_bucket_scatter
`default_nettype none

package obs_pkg;

  localparam int POS_FIELD_W = 20;
  localparam int CFG_W       = 9;

  localparam logic [CFG_W-1:0] OWNER_COUNT_RESET = 9'd256;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [31:0]            owner;
    logic [POS_FIELD_W-1:0] base_position;
    logic [31:0]            data_word_one;
    logic [31:0]            data_word_two;
    logic [31:0]            data_word_three;
  } in_beat_t;

  typedef struct packed {
    logic [POS_FIELD_W-1:0] position;
    logic [31:0]            owner_out;
    logic [31:0]            data_out_one;
    logic [31:0]            data_out_two;
    logic [31:0]            data_out_three;
    logic                   cursor_wrapped;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;   // write base position of the incoming beat
    logic place_rd;  // capture incoming record, read its cursor
    logic finish;    // write back advanced cursor, load output register
  } obs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_ok;   // incoming beat is a load inside the table
    logic place_ok;  // incoming beat is a place below the owner limit
    logic out_free;  // output register can take a result this cycle
  } obs_sts_t;

endpackage

`default_nettype wire

// ===== sv/owner_bucket_scatter.sv =====
// owner_bucket_scatter: placement pass of a counting-sort regroup (per-owner cursor table)
// load beat: no result; dropped place beat: no result
// placed record: cursor read registered, then advanced, written back and loaded into the output register;
// no new beat is taken meanwhile, and calc waits while the output register is still busy
// reset (rst_n, synchronous): owner limit 256, no result pending; cursors unset until loaded
// depends on obs_pkg, obs_ctrl, obs_datapath
`default_nettype none

module owner_bucket_scatter #(
  parameter int MAX_OWNERS    = 256,
  parameter int POSITION_BITS = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration: owner count register
  input  wire logic                      cfg_wr_en,
  input  wire logic [obs_pkg::CFG_W-1:0] cfg_wr_data,
  // input beats: cursor loads and records
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire obs_pkg::in_beat_t         in_data,
  // result beats: placed records
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output obs_pkg::out_beat_t             out_data
);

  obs_pkg::obs_cmd_t cmd;
  obs_pkg::obs_sts_t sts;

  // sequencer: idle takes a beat, calc finishes one record
  obs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // cursor table, range checks, record and output registers
  // the output register frees the input side while a result waits
  obs_datapath #(
    .MAX_OWNERS    (MAX_OWNERS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/obs_ctrl.sv =====
// obs_ctrl: sequencer for the cursor read, advance and write-back of one record
// depends on obs_pkg (command and status structs)
`default_nettype none

module obs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire obs_pkg::obs_sts_t sts,
  output obs_pkg::obs_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    state_nxt    = state_r;
    in_stall     = 1'b1;
    accept       = 1'b0;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        accept       = in_valid;
        cmd.load_wr  = accept & sts.load_ok;
        cmd.place_rd = accept & sts.place_ok;
        if (cmd.place_rd) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        // wait here while the previous result is still unclaimed
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result loaded while output register busy");

  a_place_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place_rd |=> (in_stall && !cmd.load_wr))
    else $error("new beat taken while a record is in flight");
`endif

endmodule

`default_nettype wire

// ===== sv/obs_datapath.sv =====
// obs_datapath: owner limit register, cursor memory, record register, output register
// depends on obs_pkg (beat types, command and status structs, constants)
`default_nettype none

module obs_datapath #(
  parameter int MAX_OWNERS    = 256,
  parameter int POSITION_BITS = 20
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [obs_pkg::CFG_W-1:0]      cfg_wr_data,
  input  wire obs_pkg::in_beat_t              in_data,
  input  wire obs_pkg::obs_cmd_t              cmd,
  output obs_pkg::obs_sts_t                   sts,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output obs_pkg::out_beat_t                  out_data
);

  localparam int IDX_W = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;

  logic [obs_pkg::CFG_W-1:0] owner_count_r;
  logic [POSITION_BITS-1:0]  cursor_mem [MAX_OWNERS];
  logic [POSITION_BITS-1:0]  rdata_r;
  obs_pkg::in_beat_t         item_r;
  obs_pkg::out_beat_t        out_data_r;
  logic                      out_valid_r;

  logic                      in_in_table;
  logic                      in_below_count;
  logic [IDX_W-1:0]          in_idx;
  logic [IDX_W-1:0]          item_idx;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_widx;
  logic [POSITION_BITS-1:0]  mem_wdata;
  logic [POSITION_BITS-1:0]  cursor_inc;
  logic                      wrapped;

  assign in_idx         = in_data.owner[IDX_W-1:0];
  assign item_idx       = item_r.owner[IDX_W-1:0];
  assign in_in_table    = in_data.owner < 32'(MAX_OWNERS);
  assign in_below_count = in_data.owner < 32'(owner_count_r);

  assign sts.load_ok  = (in_data.opcode == obs_pkg::OP_LOAD) && in_in_table;
  assign sts.place_ok = (in_data.opcode == obs_pkg::OP_PLACE) && in_in_table
                        && in_below_count;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign cursor_inc = rdata_r + 1'b1;
  assign wrapped    = (rdata_r == '1);

  assign mem_we    = cmd.load_wr | cmd.finish;
  assign mem_widx  = cmd.finish ? item_idx : in_idx;
  assign mem_wdata = cmd.finish ? cursor_inc
                                : POSITION_BITS'(in_data.base_position);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_count_r <= obs_pkg::OWNER_COUNT_RESET;
    end else if (cfg_wr_en) begin
      owner_count_r <= cfg_wr_data;
    end
  end

  // cursor memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cursor_mem[mem_widx] <= mem_wdata;
    end
    if (cmd.place_rd) begin
      rdata_r <= cursor_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place_rd) begin
      item_r <= in_data;
    end
    if (cmd.finish) begin
      out_data_r.position       <= obs_pkg::POS_FIELD_W'(rdata_r);
      out_data_r.owner_out      <= item_r.owner;
      out_data_r.data_out_one   <= item_r.data_word_one;
      out_data_r.data_out_two   <= item_r.data_word_two;
      out_data_r.data_out_three <= item_r.data_word_three;
      out_data_r.cursor_wrapped <= wrapped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_wr && cmd.finish))
    else $error("cursor memory written from two sources");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid && out_data.owner_out == $past(item_r.owner)))
    else $error("finished record not presented");
`endif

endmodule

`default_nettype wire
